// File: hw/rtl/pwmpdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmpdm_pkg
// Shared types and constants of the pwm period and duty meter.
// ----------------------------------------------------------------------------
package pwmpdm_pkg;

   // fixed field widths
   localparam int CLOCK_W    = 27;
   localparam int CAPTURE_W  = 16;
   localparam int TICKS_W    = 17;
   localparam int PUS_W      = 33;
   localparam int FREQ_W     = 34;
   localparam int DUTY_W     = 14;
   localparam int RSP_FIELDS_W = 2 * TICKS_W + PUS_W + FREQ_W + DUTY_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // scale constants
   localparam logic [CLOCK_W-1:0] CLOCK_RESET = 27'd120000000;
   localparam logic [CLOCK_W-1:0] US_CENTI    = 27'd100000000;
   localparam logic [6:0]         HZ_CENTI    = 7'd100;
   localparam logic [DUTY_W-1:0]  PCT_CENTI   = 14'd10000;

   // measurement phase
   typedef enum logic [1:0] {
      PH_WAIT_RISE  = 2'd0,
      PH_WAIT_FALL  = 2'd1,
      PH_WAIT_CLOSE = 2'd2
   } phase_type;

   // sequencer state
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_MUL  = 2'd1,
      ST_DIV  = 2'd2,
      ST_DONE = 2'd3
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic start_load;
      logic high_load;
      logic close;
      logic mul_step;
      logic div_step;
      logic result_load;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic high_le_period;
   } status_type;

endpackage

// File: hw/rtl/pwmpdm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmpdm_ctrl
// Edge phase tracking and sequencing of the multiply and divide steps.
// ----------------------------------------------------------------------------
module pwmpdm_ctrl
   import pwmpdm_pkg::*;
#(
   parameter int SPAN_W = 17,
   parameter int DVD_W  = 44
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic       req_tuser,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output cmd_type    cmd,
   input  status_type status
);

   localparam int CNT_W = $clog2(DVD_W);

   state_type        state_ff, state_in;
   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             out_valid_ff, out_valid_in;
   logic             accept;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_WAIT_RISE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign accept     = req_tvalid && req_tready;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (phase_ff)
                  PH_WAIT_FALL: begin
                     if (req_tuser) begin
                        // repeated rising edge restarts the measurement
                        cmd.start_load = 1'b1;
                     end else begin
                        cmd.high_load = 1'b1;
                        phase_in      = PH_WAIT_CLOSE;
                     end
                  end
                  PH_WAIT_CLOSE: begin
                     if (req_tuser) begin
                        cmd.close = 1'b1;
                        phase_in  = PH_WAIT_FALL;
                        if (status.high_le_period) begin
                           state_in = ST_MUL;
                           cnt_in   = '0;
                        end
                     end
                  end
                  default: begin
                     if (req_tuser) begin
                        cmd.start_load = 1'b1;
                        phase_in       = PH_WAIT_FALL;
                     end
                  end
               endcase
            end
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (cnt_ff == CNT_W'(SPAN_W - 1)) begin
               state_in = ST_DIV;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CNT_W'(DVD_W - 1)) begin
               state_in = ST_DONE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (!out_valid_ff || rsp_tready) begin
               cmd.result_load = 1'b1;
               out_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: hw/rtl/pwmpdm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmpdm_dp
// Tick spans, clock register and three shift-add multiply / restoring
// divide lanes for period, frequency and duty.
// ----------------------------------------------------------------------------
module pwmpdm_dp
   import pwmpdm_pkg::*;
#(
   parameter int TIMER_W = 16,
   parameter int SPAN_W  = 17,
   parameter int DVD_W   = 44,
   parameter int DVS_W   = 27
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CAPTURE_W-1:0]  capture_time,
   input  logic                  csr_write,
   input  logic [CLOCK_W-1:0]    csr_wdata,
   input  cmd_type               cmd,
   output status_type            status,
   output logic [RSP_DATA_W-1:0] rsp_data
);

   localparam int LANES  = 3;
   localparam int L_PUS  = 0;
   localparam int L_FREQ = 1;
   localparam int L_DUTY = 2;

   logic [CLOCK_W-1:0] clock_hz_ff;
   logic [TIMER_W-1:0] start_ff;
   logic [SPAN_W-1:0]  high_ff;
   logic [SPAN_W-1:0]  period_ff;
   logic [TIMER_W-1:0] cap_t;
   logic [TIMER_W-1:0] span_diff;
   logic [SPAN_W-1:0]  span;

   logic [DVD_W-1:0]   mcand_ff  [LANES];
   logic [SPAN_W-1:0]  mplier_ff [LANES];
   logic [DVD_W-1:0]   acc_ff    [LANES];
   logic [DVS_W-1:0]   dvs_ff    [LANES];
   logic [DVS_W-1:0]   rem_ff    [LANES];

   logic [TICKS_W-1:0] res_high_ff;
   logic [TICKS_W-1:0] res_period_ff;
   logic [PUS_W-1:0]   res_pus_ff;
   logic [FREQ_W-1:0]  res_freq_ff;
   logic [DUTY_W-1:0]  res_duty_ff;

   // clock frequency register
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= CLOCK_RESET;
      end else if (csr_write) begin
         clock_hz_ff <= csr_wdata;
      end
   end

   // modulo span, equal timestamps count as a full wrap
   assign cap_t     = TIMER_W'(capture_time);
   assign span_diff = cap_t - start_ff;
   assign span      = {span_diff == '0, span_diff};

   assign status.high_le_period = (high_ff <= span);

   // edge timestamps and high time
   always_ff @(posedge clock) begin
      if (cmd.start_load || cmd.close) begin
         start_ff <= cap_t;
      end
      if (cmd.high_load) begin
         high_ff <= span;
      end
      if (cmd.close) begin
         period_ff <= span;
      end
   end

   // multiply then divide lanes
   always_ff @(posedge clock) begin
      logic [DVS_W:0] trial;
      if (cmd.close) begin
         mcand_ff[L_PUS]   <= DVD_W'(US_CENTI);
         mplier_ff[L_PUS]  <= span;
         dvs_ff[L_PUS]     <= DVS_W'(clock_hz_ff);
         mcand_ff[L_FREQ]  <= DVD_W'(clock_hz_ff);
         mplier_ff[L_FREQ] <= SPAN_W'(HZ_CENTI);
         dvs_ff[L_FREQ]    <= DVS_W'(span);
         mcand_ff[L_DUTY]  <= DVD_W'(PCT_CENTI);
         mplier_ff[L_DUTY] <= high_ff;
         dvs_ff[L_DUTY]    <= DVS_W'(span);
         for (int i = 0; i < LANES; i++) begin
            acc_ff[i] <= '0;
            rem_ff[i] <= '0;
         end
      end else if (cmd.mul_step) begin
         for (int i = 0; i < LANES; i++) begin
            if (mplier_ff[i][0]) begin
               acc_ff[i] <= acc_ff[i] + mcand_ff[i];
            end
            mcand_ff[i]  <= {mcand_ff[i][DVD_W-2:0], 1'b0};
            mplier_ff[i] <= {1'b0, mplier_ff[i][SPAN_W-1:1]};
         end
      end else if (cmd.div_step) begin
         // restoring division, quotient bits shift into the dividend
         for (int i = 0; i < LANES; i++) begin
            trial = {rem_ff[i], acc_ff[i][DVD_W-1]};
            if (trial >= {1'b0, dvs_ff[i]}) begin
               rem_ff[i] <= DVS_W'(trial - {1'b0, dvs_ff[i]});
               acc_ff[i] <= {acc_ff[i][DVD_W-2:0], 1'b1};
            end else begin
               rem_ff[i] <= trial[DVS_W-1:0];
               acc_ff[i] <= {acc_ff[i][DVD_W-2:0], 1'b0};
            end
         end
      end
   end

   // output register, period in centi-us saturates
   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         res_high_ff   <= TICKS_W'(high_ff);
         res_period_ff <= TICKS_W'(period_ff);
         if (|acc_ff[L_PUS][DVD_W-1:PUS_W]) begin
            res_pus_ff <= '1;
         end else begin
            res_pus_ff <= acc_ff[L_PUS][PUS_W-1:0];
         end
         res_freq_ff <= acc_ff[L_FREQ][FREQ_W-1:0];
         res_duty_ff <= acc_ff[L_DUTY][DUTY_W-1:0];
      end
   end

   assign rsp_data = {(RSP_DATA_W - RSP_FIELDS_W)'(0), res_duty_ff, res_freq_ff,
                      res_pus_ff, res_period_ff, res_high_ff};

endmodule

// File: hw/rtl/pwm_period_duty_meter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_period_duty_meter_core
// Measures high time, period, frequency and duty of a pwm input from its
// edge captures.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                content
//  req_      in         req_tvalid/req_tready    one edge: polarity, timestamp
//  rsp_      out        rsp_tvalid/rsp_tready    one measurement
//  csr_      in         csr_valid/csr_ready      capture timer clock in hertz
//
//  edges that close no measurement leave the block ready for the next edge.
//  a closing rising edge with a valid period holds req_tready low while
//  the three shift-add multiply and restoring divide lanes retire one bit
//  per cycle, through the multiply, divide and done states.
//  a finished measurement waits in the output register; a stalled rsp_ side
//  only holds the block once the next measurement is done.
//  reset sets the clock to 120 MHz and waits for a rising edge.
// ----------------------------------------------------------------------------
module pwm_period_duty_meter_core
   import pwmpdm_pkg::*;
#(
   parameter int TIMER_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // tdata: capture_time[15:0]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [CAPTURE_W-1:0]  req_tdata,
   // tuser: edge_rising[0]
   input  logic                  req_tuser,
   // tdata: high_ticks[16:0], period_ticks[33:17], period_centi_us[66:34],
   //        freq_centi_hz[100:67], duty_centi_pct[114:101], zeros[119:115]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CLOCK_W-1:0]    csr_wdata
);

   localparam int SPAN_W = TIMER_WIDTH + 1;
   localparam int DVD_W  = CLOCK_W + SPAN_W;
   localparam int DVS_W  = (SPAN_W > CLOCK_W) ? SPAN_W : CLOCK_W;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   // sequencer
   pwmpdm_ctrl #(
      .SPAN_W (SPAN_W),
      .DVD_W  (DVD_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // arithmetic
   pwmpdm_dp #(
      .TIMER_W (TIMER_WIDTH),
      .SPAN_W  (SPAN_W),
      .DVD_W   (DVD_W),
      .DVS_W   (DVS_W)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .capture_time (req_tdata),
      .csr_write    (csr_valid && csr_ready),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .status       (status),
      .rsp_data     (rsp_tdata)
   );

endmodule

// File: hw/rtl/pwmpdm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmpdm_checker
// Port level checks of the pwm period and duty meter, bound to the core.
// ----------------------------------------------------------------------------
module pwmpdm_checker
   import pwmpdm_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [TICKS_W-1:0] high_ticks;
   logic [TICKS_W-1:0] period_ticks;
   logic [DUTY_W-1:0]  duty;

   assign high_ticks   = rsp_tdata[TICKS_W-1:0];
   assign period_ticks = rsp_tdata[2*TICKS_W-1:TICKS_W];
   assign duty         = rsp_tdata[RSP_FIELDS_W-1:RSP_FIELDS_W-DUTY_W];

   // a stalled response holds its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // high time never exceeds a nonzero period
   a_high_le_period: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (period_ticks != '0) && (high_ticks <= period_ticks))
      else $error("high time above period");

   // duty stays within one hundred percent
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> duty <= PCT_CENTI)
      else $error("duty above full scale");

   // a falling edge never makes a result appear in the next cycle
   a_fall_no_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result after falling edge");

   // padding bits stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:RSP_FIELDS_W] == '0)
      else $error("nonzero padding");

endmodule

bind pwm_period_duty_meter_core pwmpdm_checker u_pwmpdm_checker (.*);
